// ----- hdl/hrp_pkg.sv -----
// Shared types, codes and character tables for the HTTP request header parser.
package hrp_pkg;

    // Parser phase, one-hot
    typedef enum logic [9:0] {
        PH_VERB    = 10'b00_0000_0001,
        PH_PATH    = 10'b00_0000_0010,
        PH_RLREST  = 10'b00_0000_0100,
        PH_RL_LF   = 10'b00_0000_1000,
        PH_HDR     = 10'b00_0001_0000,
        PH_HDR_NUM = 10'b00_0010_0000,
        PH_HDR_LF  = 10'b00_0100_0000,
        PH_END_LF  = 10'b00_1000_0000,
        PH_BODY    = 10'b01_0000_0000,
        PH_ERROR   = 10'b10_0000_0000
    } t_phase;

    // Byte class codes
    localparam logic [3:0] CLS_VERB     = 4'd0;
    localparam logic [3:0] CLS_VERB_SP  = 4'd1;
    localparam logic [3:0] CLS_PATH     = 4'd2;
    localparam logic [3:0] CLS_PATH_SP  = 4'd3;
    localparam logic [3:0] CLS_RL_REST  = 4'd4;
    localparam logic [3:0] CLS_HEADER   = 4'd5;
    localparam logic [3:0] CLS_LINE_END = 4'd6;
    localparam logic [3:0] CLS_BODY     = 4'd7;
    localparam logic [3:0] CLS_IGNORED  = 4'd8;

    // Characters
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_C  = 8'h43;
    localparam logic [7:0] CH_LOW_C = 8'h63;

    // Column limits within a header line
    localparam logic [4:0] COL_LEN_END   = 5'd16;
    localparam logic [4:0] COL_CONN_END  = 5'd12;
    localparam logic [4:0] COL_WORD_LAST = 5'd17;
    localparam logic [4:0] COL_TAIL_BASE = 5'd13;
    localparam logic [4:0] COL_MAX       = 5'd31;

    // Control state that travels between the registers and the step logic
    typedef struct packed {
        t_phase     phase;
        logic [4:0] column;
        logic       len_match;
        logic       conn_match;
        logic       close_match;
        logic       digits_active;
        logic       conn_persist;
        logic       verb_seen;
        logic       path_seen;
    } t_ctrl;

    localparam t_ctrl CTRL_START = '{
        phase:         PH_VERB,
        column:        5'd0,
        len_match:     1'b1,
        conn_match:    1'b1,
        close_match:   1'b1,
        digits_active: 1'b1,
        conn_persist:  1'b1,
        verb_seen:     1'b0,
        path_seen:     1'b0
    };

    // One result beat
    typedef struct packed {
        logic [3:0]  byte_class;
        logic [7:0]  echo_byte;
        logic        request_done;
        logic        request_error;
        logic        conn_persist;
        logic [31:0] content_length;
    } t_result;

    // "Content-Length: "
    function automatic logic [7:0] len_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = 8'h43; // C
            4'd1:    ch = 8'h6F; // o
            4'd2:    ch = 8'h6E; // n
            4'd3:    ch = 8'h74; // t
            4'd4:    ch = 8'h65; // e
            4'd5:    ch = 8'h6E; // n
            4'd6:    ch = 8'h74; // t
            4'd7:    ch = 8'h2D; // -
            4'd8:    ch = 8'h4C; // L
            4'd9:    ch = 8'h65; // e
            4'd10:   ch = 8'h6E; // n
            4'd11:   ch = 8'h67; // g
            4'd12:   ch = 8'h74; // t
            4'd13:   ch = 8'h68; // h
            4'd14:   ch = 8'h3A; // :
            default: ch = 8'h20; // space
        endcase
        return ch;
    endfunction

    // "Connection: "
    function automatic logic [7:0] conn_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = 8'h43; // C
            4'd1:    ch = 8'h6F; // o
            4'd2:    ch = 8'h6E; // n
            4'd3:    ch = 8'h6E; // n
            4'd4:    ch = 8'h65; // e
            4'd5:    ch = 8'h63; // c
            4'd6:    ch = 8'h74; // t
            4'd7:    ch = 8'h69; // i
            4'd8:    ch = 8'h6F; // o
            4'd9:    ch = 8'h6E; // n
            4'd10:   ch = 8'h3A; // :
            default: ch = 8'h20; // space
        endcase
        return ch;
    endfunction

    // Tail of "close" after the first letter
    function automatic logic [7:0] lose_char(input logic [1:0] idx);
        logic [7:0] ch;
        case (idx)
            2'd0:    ch = 8'h6C; // l
            2'd1:    ch = 8'h6F; // o
            2'd2:    ch = 8'h73; // s
            default: ch = 8'h65; // e
        endcase
        return ch;
    endfunction

endpackage

// ----- hdl/hrp_step.sv -----
// Per-byte step logic: classes one byte and works out the next parser state.
module hrp_step #(
    parameter int LENGTH_WIDTH = 32
) (
    input  hrp_pkg::t_ctrl          i_ctrl,
    input  logic [LENGTH_WIDTH-1:0] i_pending,
    input  logic [LENGTH_WIDTH-1:0] i_length,
    input  logic [LENGTH_WIDTH-1:0] i_body_left,
    input  logic [7:0]              i_byte,
    input  logic                    i_restart,
    output hrp_pkg::t_ctrl          o_ctrl,
    output logic [LENGTH_WIDTH-1:0] o_pending,
    output logic [LENGTH_WIDTH-1:0] o_length,
    output logic [LENGTH_WIDTH-1:0] o_body_left,
    output hrp_pkg::t_result        o_result
);
    import hrp_pkg::*;

    localparam logic [LENGTH_WIDTH-1:0] LEN_MAX = '1;

    t_ctrl                   ctrl;
    logic [LENGTH_WIDTH-1:0] pend;
    logic [LENGTH_WIDTH-1:0] len;
    logic [LENGTH_WIDTH-1:0] body;
    logic [LENGTH_WIDTH+3:0] pend_wide;
    logic [LENGTH_WIDTH+3:0] prod;
    logic [63:0]             len_ext;
    logic [4:0]              col;
    logic [4:0]              tail_idx;
    logic [3:0]              cls;
    logic                    digit;
    logic                    done;

    always_comb begin
        // restart clears the request before this byte is handled
        if (i_restart) begin
            ctrl = CTRL_START;
            pend = '0;
            len  = '0;
            body = '0;
        end else begin
            ctrl = i_ctrl;
            pend = i_pending;
            len  = i_length;
            body = i_body_left;
        end

        // value * 10 + digit, overflow shows in the top four bits
        digit     = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
        pend_wide = {4'b0000, pend};
        prod      = (pend_wide << 3) + (pend_wide << 1)
                  + {{LENGTH_WIDTH{1'b0}}, i_byte[3:0]};
        col       = ctrl.column;
        tail_idx  = col - COL_TAIL_BASE;
        cls       = CLS_IGNORED;
        done      = 1'b0;

        unique case (ctrl.phase)
            PH_VERB, PH_PATH: begin
                if (i_byte == CH_CR) begin
                    cls        = CLS_LINE_END;
                    ctrl.phase = PH_ERROR;
                end else if (i_byte == CH_SP) begin
                    if (ctrl.phase == PH_VERB) begin
                        cls            = CLS_VERB_SP;
                        ctrl.verb_seen = 1'b1;
                        ctrl.phase     = PH_PATH;
                    end else begin
                        cls            = CLS_PATH_SP;
                        ctrl.path_seen = 1'b1;
                        ctrl.phase     = PH_RLREST;
                    end
                end else begin
                    cls = (ctrl.phase == PH_VERB) ? CLS_VERB : CLS_PATH;
                end
            end
            PH_RLREST: begin
                if (i_byte == CH_CR) begin
                    cls        = CLS_LINE_END;
                    ctrl.phase = PH_RL_LF;
                end else begin
                    cls = CLS_RL_REST;
                end
            end
            PH_RL_LF, PH_HDR_LF: begin
                // byte after CR, taken unchecked; new header line
                cls                = CLS_LINE_END;
                ctrl.column        = 5'd0;
                ctrl.len_match     = 1'b1;
                ctrl.conn_match    = 1'b1;
                ctrl.close_match   = 1'b1;
                ctrl.digits_active = 1'b1;
                pend               = '0;
                ctrl.phase         = PH_HDR;
            end
            PH_HDR, PH_HDR_NUM: begin
                if (i_byte == CH_CR) begin
                    // commit the line's findings
                    cls = CLS_LINE_END;
                    if (col >= COL_LEN_END && ctrl.len_match) begin
                        len = pend;
                    end
                    if (col >= COL_WORD_LAST && ctrl.conn_match && ctrl.close_match) begin
                        ctrl.conn_persist = 1'b0;
                    end
                    ctrl.phase = (col == 5'd0) ? PH_END_LF : PH_HDR_LF;
                end else begin
                    cls = CLS_HEADER;
                    // Content-Length name and value
                    if (col < COL_LEN_END) begin
                        if (i_byte != len_char(col[3:0])) begin
                            ctrl.len_match = 1'b0;
                        end
                    end else if (ctrl.len_match && ctrl.digits_active) begin
                        if (ctrl.phase == PH_HDR) begin
                            if (digit) begin
                                pend       = {{(LENGTH_WIDTH-4){1'b0}}, i_byte[3:0]};
                                ctrl.phase = PH_HDR_NUM;
                            end else if (i_byte != CH_SP) begin
                                ctrl.digits_active = 1'b0;
                            end
                        end else if (digit) begin
                            pend = (prod[LENGTH_WIDTH+3:LENGTH_WIDTH] != 4'd0)
                                 ? LEN_MAX : prod[LENGTH_WIDTH-1:0];
                        end else begin
                            ctrl.digits_active = 1'b0;
                        end
                    end
                    // Connection name and close word
                    if (col < COL_CONN_END) begin
                        if (i_byte != conn_char(col[3:0])) begin
                            ctrl.conn_match = 1'b0;
                        end
                    end else if (col == COL_CONN_END) begin
                        if (i_byte != CH_UP_C && i_byte != CH_LOW_C) begin
                            ctrl.close_match = 1'b0;
                        end
                    end else if (col < COL_WORD_LAST) begin
                        if (i_byte != lose_char(tail_idx[1:0])) begin
                            ctrl.close_match = 1'b0;
                        end
                    end
                    if (col < COL_MAX) begin
                        ctrl.column = col + 5'd1;
                    end
                end
            end
            PH_END_LF: begin
                cls = CLS_LINE_END;
                if (len == '0) begin
                    done = 1'b1;
                end else begin
                    body       = len;
                    ctrl.phase = PH_BODY;
                end
            end
            PH_BODY: begin
                cls = CLS_BODY;
                if (body != '0) begin
                    body = body - {{(LENGTH_WIDTH-1){1'b0}}, 1'b1};
                end
                if (body == '0) begin
                    done = 1'b1;
                end
            end
            default: begin
                cls = CLS_IGNORED;
            end
        endcase

        // result shows the state after this byte
        len_ext                  = 64'(len);
        o_result.byte_class      = cls;
        o_result.echo_byte       = i_byte;
        o_result.request_done    = done;
        o_result.request_error   = (ctrl.phase == PH_ERROR);
        o_result.conn_persist    = ctrl.conn_persist;
        o_result.content_length  = len_ext[31:0];

        // finished request: start afresh
        if (done) begin
            o_ctrl      = CTRL_START;
            o_pending   = '0;
            o_length    = '0;
            o_body_left = '0;
        end else begin
            o_ctrl      = ctrl;
            o_pending   = pend;
            o_length    = len;
            o_body_left = body;
        end
    end

endmodule

// ----- hdl/http_request_header_parser_unit.sv -----
// Top level of the HTTP request header parser: input register, parser state, result register.
//
//  channel  | dir | tdata                              | tuser          | tlast
//  ---------+-----+------------------------------------+----------------+-------------
//  s_axis   | in  | [7:0] data_byte                    | [0] restart    | -
//  m_axis   | out | [7:0] echo_byte, [8] request_error,| [3:0] class    | request_done
//           |     | [9] conn_persist, [41:10] cont. len|                |
//
// One byte per clock sustained while m_axis does not stall; a byte passes the input
// register and then leaves through the result register.
// The state update is a single pass of compare and shift-add logic per byte.
// Synchronous active-low reset puts the parser at the verb of a new request.
// A stalled m_axis holds its beat; s_axis then takes one more beat and stops.
module http_request_header_parser_unit #(
    parameter int LENGTH_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_axis_tuser,   // [0] restart
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [7:0] echo_byte, [8] request_error,
                                        // [9] conn_persist, [41:10] content_length, rest 0
    output logic [3:0]  m_axis_tuser,   // [3:0] byte_class
    output logic        m_axis_tlast    // request_done
);
    import hrp_pkg::*;

    logic                    r_in_valid;
    logic [7:0]              r_in_byte;
    logic                    r_in_restart;
    logic                    r_out_valid;
    t_result                 r_out;
    t_ctrl                   r_ctrl;
    logic [LENGTH_WIDTH-1:0] r_pending;
    logic [LENGTH_WIDTH-1:0] r_length;
    logic [LENGTH_WIDTH-1:0] r_body_left;

    t_ctrl                   n_ctrl;
    logic [LENGTH_WIDTH-1:0] n_pending;
    logic [LENGTH_WIDTH-1:0] n_length;
    logic [LENGTH_WIDTH-1:0] n_body_left;
    t_result                 n_out;
    logic                    advance;

    // a byte moves on when the result register is free or draining
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte    <= s_axis_tdata;
            r_in_restart <= s_axis_tuser[0];
        end
    end

    hrp_step #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_step (
        .i_ctrl      (r_ctrl),
        .i_pending   (r_pending),
        .i_length    (r_length),
        .i_body_left (r_body_left),
        .i_byte      (r_in_byte),
        .i_restart   (r_in_restart),
        .o_ctrl      (n_ctrl),
        .o_pending   (n_pending),
        .o_length    (n_length),
        .o_body_left (n_body_left),
        .o_result    (n_out)
    );

    // parser state, updated once per byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl      <= CTRL_START;
            r_pending   <= '0;
            r_length    <= '0;
            r_body_left <= '0;
        end else if (advance) begin
            r_ctrl      <= n_ctrl;
            r_pending   <= n_pending;
            r_length    <= n_length;
            r_body_left <= n_body_left;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out.content_length, r_out.conn_persist,
                            r_out.request_error, r_out.echo_byte};
    assign m_axis_tuser  = r_out.byte_class;
    assign m_axis_tlast  = r_out.request_done;

endmodule

// ----- hdl/hrp_checker.sv -----
// Port-level checks for the HTTP request header parser, bound to the top level.
module hrp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [3:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    import hrp_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result beat changed while stalled");

    // class code stays within its range
    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser <= CLS_IGNORED)
        else $error("byte class out of range");

    // a request finishes only on a line end or body byte, never in error
    a_done_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |->
            (m_axis_tuser == CLS_LINE_END || m_axis_tuser == CLS_BODY)
            && !m_axis_tdata[8])
        else $error("request done on a wrong byte");

    // once in error only the failing CR or ignored bytes come out
    a_error_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[8] |->
            (m_axis_tuser == CLS_LINE_END || m_axis_tuser == CLS_IGNORED))
        else $error("error flag on a wrong byte class");

    // input side keeps flowing while the result register is free
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid && $past(!m_axis_tvalid) && $past(i_rst_n) |-> s_axis_tready)
        else $error("input stalled with an empty output");

endmodule

bind http_request_header_parser_unit hrp_checker u_hrp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ----- test/http_request_header_parser_unit_test.sv -----
// Self-checking testbench for the HTTP request header parser unit.
module http_request_header_parser_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import hrp_pkg::*;

    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam int         RANDOM_ITEMS = 550;
    localparam int         SINK_STALL   = 150;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] data_byte
    logic [0:0]  s_axis_tuser;   // [0] restart
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // [7:0] echo_byte, [8] request_error, [9] conn_persist,
                                 // [41:10] content_length, rest 0
    logic [3:0]  m_axis_tuser;   // [3:0] byte_class
    logic        m_axis_tlast;   // request_done

    http_request_header_parser_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Header names matched by the parser
    string len_name  = "Content-Length: ";
    string conn_name = "Connection: ";
    string lose_tail = "lose";

    // Parser state mirrored by the predictor
    t_phase      ph;
    logic [4:0]  col;
    logic        len_ok;
    logic        conn_ok;
    logic        close_ok;
    logic        digits_on;
    logic [31:0] pending_len;
    logic [31:0] committed_len;
    logic [31:0] body_left;
    logic        keep_flag;
    logic        verb_seen;
    logic        path_seen;

    t_result     parsed_q[$];
    int          error_count   = 0;
    int          counted_bytes = 0;
    bit          tx_idle       = 1'b1;
    bit          rx_idle       = 1'b1;
    bit          arm_restart   = 1'b0;
    int          sink_hold     = 0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void start_line();
        col         = 5'd0;
        len_ok      = 1'b1;
        conn_ok     = 1'b1;
        close_ok    = 1'b1;
        digits_on   = 1'b1;
        pending_len = 32'd0;
    endfunction

    function automatic void start_request();
        start_line();
        ph            = PH_VERB;
        committed_len = 32'd0;
        body_left     = 32'd0;
        keep_flag     = 1'b1;
        verb_seen     = 1'b0;
        path_seen     = 1'b0;
    endfunction

    // One byte of a header line: name match, value digits, close word
    function automatic void header_char(input logic [7:0] b);
        logic [4:0]  c;
        logic        digit;
        logic [63:0] d;
        logic [63:0] lim;
        c     = col;
        digit = (b >= CH_ZERO) && (b <= CH_NINE);
        d     = 64'(b - CH_ZERO);
        lim   = 64'hFFFF_FFFF;
        if (c < COL_LEN_END) begin
            if (b != len_name[c]) len_ok = 1'b0;
        end else if (len_ok && digits_on) begin
            if (ph == PH_HDR) begin
                if (digit) begin
                    pending_len = d[31:0];
                    ph          = PH_HDR_NUM;
                end else if (b != CH_SP) begin
                    digits_on = 1'b0;
                end
            end else if (digit) begin
                // saturate rather than wrap
                if ({32'd0, pending_len} > (lim - d) / 64'd10)
                    pending_len = '1;
                else
                    pending_len = pending_len * 32'd10 + d[31:0];
            end else begin
                digits_on = 1'b0;
            end
        end
        if (c < COL_CONN_END) begin
            if (b != conn_name[c]) conn_ok = 1'b0;
        end else if (c == COL_CONN_END) begin
            if (b != CH_UP_C && b != CH_LOW_C) close_ok = 1'b0;
        end else if (c < COL_WORD_LAST) begin
            if (b != lose_tail[c - COL_TAIL_BASE]) close_ok = 1'b0;
        end
        if (c < COL_MAX) col = c + 5'd1;
    endfunction

    // Classify one accepted byte and advance the mirrored state
    function automatic t_result parse_byte(input logic [7:0] b, input logic rs);
        t_result    r;
        logic [3:0] cls;
        logic       done;
        if (rs) start_request();
        cls  = CLS_IGNORED;
        done = 1'b0;
        case (ph)
            PH_VERB, PH_PATH: begin
                if (b == CH_CR) begin
                    cls = CLS_LINE_END;
                    ph  = PH_ERROR;
                end else if (b == CH_SP) begin
                    if (ph == PH_VERB) begin
                        cls       = CLS_VERB_SP;
                        verb_seen = 1'b1;
                        ph        = PH_PATH;
                    end else begin
                        cls       = CLS_PATH_SP;
                        path_seen = 1'b1;
                        ph        = PH_RLREST;
                    end
                end else begin
                    cls = (ph == PH_VERB) ? CLS_VERB : CLS_PATH;
                end
            end
            PH_RLREST: begin
                if (b == CH_CR) begin
                    cls = CLS_LINE_END;
                    ph  = PH_RL_LF;
                end else begin
                    cls = CLS_RL_REST;
                end
            end
            PH_RL_LF, PH_HDR_LF: begin
                cls = CLS_LINE_END;
                start_line();
                ph = PH_HDR;
            end
            PH_HDR, PH_HDR_NUM: begin
                if (b == CH_CR) begin
                    cls = CLS_LINE_END;
                    if (col >= COL_LEN_END && len_ok) committed_len = pending_len;
                    if (col >= COL_WORD_LAST && conn_ok && close_ok) keep_flag = 1'b0;
                    ph = (col == 5'd0) ? PH_END_LF : PH_HDR_LF;
                end else begin
                    cls = CLS_HEADER;
                    header_char(b);
                end
            end
            PH_END_LF: begin
                cls = CLS_LINE_END;
                if (committed_len == 32'd0) begin
                    done = 1'b1;
                end else begin
                    body_left = committed_len;
                    ph        = PH_BODY;
                end
            end
            PH_BODY: begin
                cls = CLS_BODY;
                if (body_left > 32'd0) body_left = body_left - 32'd1;
                if (body_left == 32'd0) done = 1'b1;
            end
            default: cls = CLS_IGNORED;
        endcase
        r.byte_class     = cls;
        r.echo_byte      = b;
        r.request_done   = done;
        r.request_error  = (ph == PH_ERROR);
        r.conn_persist   = keep_flag;
        r.content_length = committed_len;
        if (done) start_request();
        return r;
    endfunction

    // ---------------------------------------------------------------- sender

    // Offer one byte, wait for its beat, record the expected result
    task automatic send_byte(input logic [7:0] b, input logic rs);
        int      gap;
        logic    rs_eff;
        t_result want;
        rs_eff      = rs | arm_restart;
        arm_restart = 1'b0;
        gap         = tx_idle ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= rs_eff;
        do @(posedge i_clk); while (!s_axis_tready);
        want = parse_byte(b, rs_eff);
        parsed_q.push_back(want);
        counted_bytes++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
    endtask

    task automatic end_line();
        send_byte(CH_CR, 1'b0);
        send_byte(($urandom_range(0, 3) == 0) ? 8'($urandom) : CH_LF, 1'b0);
    endtask

    // Drop valid, wait for every result and let the pipeline settle
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (parsed_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------- receiver

    initial begin : result_sink
        int gap;
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (sink_hold > 0) begin
                m_axis_tready <= 1'b0;
                repeat (sink_hold) @(posedge i_clk);
                sink_hold = 0;
            end
            gap = rx_idle ? $urandom_range(0, 4) : 0;
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endtask

    // Compare every result beat with the oldest prediction
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (parsed_q.size() == 0) begin
                $error("result beat with no byte outstanding");
                error_count++;
            end else begin
                want = parsed_q.pop_front();
                check_field("byte_class", 32'(want.byte_class), 32'(m_axis_tuser));
                check_field("echo_byte", 32'(want.echo_byte), 32'(m_axis_tdata[7:0]));
                check_field("request_done", 32'(want.request_done), 32'(m_axis_tlast));
                check_field("request_error", 32'(want.request_error),
                            32'(m_axis_tdata[8]));
                check_field("conn_persist", 32'(want.conn_persist), 32'(m_axis_tdata[9]));
                check_field("content_length", want.content_length, m_axis_tdata[41:10]);
            end
        end
    end

    // ---------------------------------------------------------------- generators

    // Any byte but space and CR, mostly printable
    function automatic logic [7:0] token_char();
        logic [7:0] c;
        if ($urandom_range(0, 3) != 0) return 8'($urandom_range(8'h21, 8'h7E));
        do c = 8'($urandom); while (c == CH_SP || c == CH_CR);
        return c;
    endfunction

    function automatic string token_text(input int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++) s = {s, " "};
        for (int i = 0; i < n; i++) s.putc(i, token_char());
        return s;
    endfunction

    function automatic string length_text();
        case ($urandom_range(0, 11))
            0:       return "4294967295";
            1:       return "4294967296";
            2:       return "99999999999999999999";
            3:       return "";
            4:       return "0003";
            5:       return $sformatf("%0dx9", $urandom_range(0, 5));
            6:       return $sformatf("%0d 7", $urandom_range(0, 5));
            default: return $sformatf("%0d", $urandom_range(0, 6));
        endcase
    endfunction

    function automatic string close_text();
        case ($urandom_range(0, 8))
            0:       return "Close";
            1:       return "close";
            2:       return "Clos";
            3:       return "closed";
            4:       return "cLose";
            5:       return "keep-alive";
            6:       return "Closer";
            7:       return "c";
            default: return "close ";
        endcase
    endfunction

    task automatic send_header_line();
        string s;
        int    idx;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                s = len_name;
                repeat ($urandom_range(0, 2)) s = {s, " "};
                s = {s, length_text()};
            end
            3, 4: s = {conn_name, close_text()};
            5: begin
                // name or value with one byte replaced
                s   = ($urandom_range(0, 1) == 0) ? {len_name, "5"} : {conn_name, "close"};
                idx = $urandom_range(0, s.len() - 1);
                s.putc(idx, token_char());
            end
            6: s = {"X-Forwarded-Something-Long: ", token_text($urandom_range(4, 14))};
            7: s = ($urandom_range(0, 1) == 0) ? "Content-Length:" : "Connection: Clo";
            default: s = {"Host: ", token_text($urandom_range(0, 6))};
        endcase
        send_text(s);
        end_line();
    endtask

    // Complete request with random headers and a body where the length allows
    task automatic send_good_request();
        int k;
        if ($urandom_range(0, 7) == 0) arm_restart = 1'b1;
        send_text(token_text($urandom_range(0, 4)));
        send_byte(CH_SP, 1'b0);
        send_text({"/", token_text($urandom_range(0, 5))});
        send_byte(CH_SP, 1'b0);
        if ($urandom_range(0, 1) == 0) send_text("HTTP/1.1");
        else send_text(token_text($urandom_range(0, 6)));
        end_line();
        repeat ($urandom_range(0, 4)) send_header_line();
        end_line();
        k = 0;
        while (ph == PH_BODY && k < 12) begin
            send_byte(8'($urandom), 1'b0);
            k++;
        end
        // body too long to send: the next request is sent with restart
        if (ph == PH_BODY) arm_restart = 1'b1;
    endtask

    // Request line cut short by a CR, followed by bytes that are ignored
    task automatic send_broken_request();
        send_text(token_text($urandom_range(0, 4)));
        if ($urandom_range(0, 1) == 0) begin
            send_byte(CH_SP, 1'b0);
            send_text(token_text($urandom_range(0, 4)));
        end
        send_byte(CH_CR, 1'b0);
        repeat ($urandom_range(0, 4)) send_byte(8'($urandom), 1'b0);
        arm_restart = 1'b1;
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 6))
            send_byte(8'($urandom), ($urandom_range(0, 3) == 0));
        arm_restart = 1'b1;
    endtask

    // ---------------------------------------------------------------- tests

    // CR in the verb, ignored bytes, then CR in the path after a restart
    task automatic test_malformed_line();
        send_byte(CH_CR, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h47, 1'b1);
        send_text("E /");
        send_byte(CH_CR, 1'b0);
        drain_results();
    endtask

    // Empty verb and path, no headers, done on the final line end
    task automatic test_empty_fields();
        send_byte(CH_SP, 1'b1);
        send_byte(CH_SP, 1'b0);
        send_byte(CH_CR, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(CH_CR, 1'b0);
        send_byte(8'hFF, 1'b0);
        drain_results();
    endtask

    // Restart partway through a request line
    task automatic test_restart_mid_request();
        send_text("AB /");
        send_byte(8'h43, 1'b1);
        send_text(" / H");
        send_byte(CH_CR, 1'b0);
        send_byte(CH_LF, 1'b0);
        send_byte(CH_CR, 1'b0);
        send_byte(CH_LF, 1'b0);
        drain_results();
    endtask

    // Receiver holds off while the sender keeps offering bytes
    task automatic test_output_backpressure();
        tx_idle     = 1'b0;
        sink_hold   = SINK_STALL;
        arm_restart = 1'b1;
        repeat (3) send_good_request();
        drain_results();
        tx_idle = 1'b1;
    endtask

    // Mostly well-formed requests, some broken ones and some noise, up to the byte budget
    task automatic test_random_traffic();
        int pick;
        arm_restart = 1'b1;
        while (counted_bytes < RANDOM_ITEMS) begin
            if ($urandom_range(0, 5) == 0) begin
                tx_idle = ($urandom_range(0, 2) != 0);
                rx_idle = ($urandom_range(0, 2) != 0);
            end
            pick = $urandom_range(0, 9);
            if (pick < 7) send_good_request();
            else if (pick < 9) send_broken_request();
            else send_noise();
        end
        drain_results();
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        s_axis_tuser  <= 1'b0;
        start_request();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_malformed_line();
        test_empty_fields();
        test_restart_mid_request();
        test_output_backpressure();
        test_random_traffic();

        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/hrp_pkg.sv
hdl/hrp_step.sv
hdl/http_request_header_parser_unit.sv
hdl/hrp_checker.sv
test/http_request_header_parser_unit_test.sv
